/* hw/rtl/lcfe_pkg.sv */
// Shared types and constants for the LED chain frame encoder.
// No dependencies; the controller, datapath and top level refer to it by scoped names.

package lcfe_pkg;

    // Pixel word layout: green in [23:16], red in [15:8], blue in [7:0].
    localparam int PIX_W        = 24;
    localparam int BITS_PER_LED = 24;
    localparam int DEFAULT_LEDS = 64;

    // Register reset values.
    localparam logic [7:0]  CHAIN_LEN_RST = 8'd64;
    localparam logic [15:0] ONE_DUTY_RST  = 16'd60;
    localparam logic [15:0] ZERO_DUTY_RST = 16'd30;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_CHAIN_LEN = 2'd0;
    localparam logic [1:0] REG_ONE_DUTY  = 2'd1;
    localparam logic [1:0] REG_ZERO_DUTY = 2'd2;

    typedef enum logic [2:0] {
        OP_SET_PIXEL = 3'd0,
        OP_SET_ALL   = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_SHOW      = 3'd3,
        OP_SLOT_TICK = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_DRAIN,
        ST_BIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill_begin;
        logic fill_clear;
        logic fill_wr;
        logic copy_begin;
        logic copy_rd;
        logic pixel_wr;
        logic tick_rd;
        logic emit_bit;
        logic emit_rst;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_active;
        logic in_reset;
        logic sweep_last;
        logic fill_nonempty;
    } status_t;

endpackage

/* hw/rtl/lcfe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the pixel store and the frame store; no dependencies.

module lcfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/lcfe_ctrl.sv */
// Controller state machine of the LED chain frame encoder.
// Depends on lcfe_pkg for the state, operation, command and status types.

module lcfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        operation,
    input  lcfe_pkg::status_t status,
    output lcfe_pkg::cmd_t    cmd,
    output logic              busy
);

    lcfe_pkg::state_t state_reg;
    lcfe_pkg::state_t state_next;
    lcfe_pkg::op_t    op;
    logic             accept;

    assign op     = lcfe_pkg::op_t'(operation);
    assign accept = start && (state_reg == lcfe_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcfe_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcfe_pkg::ST_INIT, lcfe_pkg::ST_FILL:
            begin
                if (status.sweep_last)
                begin
                    state_next = lcfe_pkg::ST_IDLE;
                end
            end
            lcfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        lcfe_pkg::OP_SET_ALL:
                        begin
                            if (status.fill_nonempty)
                            begin
                                state_next = lcfe_pkg::ST_FILL;
                            end
                        end
                        lcfe_pkg::OP_CLEAR:
                        begin
                            state_next = lcfe_pkg::ST_FILL;
                        end
                        lcfe_pkg::OP_SHOW:
                        begin
                            if (!status.frame_active)
                            begin
                                state_next = lcfe_pkg::ST_COPY;
                            end
                        end
                        lcfe_pkg::OP_SLOT_TICK:
                        begin
                            if (status.frame_active && !status.in_reset)
                            begin
                                state_next = lcfe_pkg::ST_BIT;
                            end
                        end
                        default:
                        begin
                            state_next = lcfe_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lcfe_pkg::ST_COPY:
            begin
                if (status.sweep_last)
                begin
                    state_next = lcfe_pkg::ST_DRAIN;
                end
            end
            lcfe_pkg::ST_DRAIN, lcfe_pkg::ST_BIT:
            begin
                state_next = lcfe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lcfe_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != lcfe_pkg::ST_IDLE);
        case (state_reg)
            lcfe_pkg::ST_INIT, lcfe_pkg::ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
            end
            lcfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        lcfe_pkg::OP_SET_PIXEL:
                        begin
                            cmd.pixel_wr = 1'b1;
                        end
                        lcfe_pkg::OP_SET_ALL:
                        begin
                            cmd.fill_begin = status.fill_nonempty;
                        end
                        lcfe_pkg::OP_CLEAR:
                        begin
                            cmd.fill_begin = 1'b1;
                            cmd.fill_clear = 1'b1;
                        end
                        lcfe_pkg::OP_SHOW:
                        begin
                            cmd.copy_begin = !status.frame_active;
                        end
                        lcfe_pkg::OP_SLOT_TICK:
                        begin
                            cmd.tick_rd  = status.frame_active && !status.in_reset;
                            cmd.emit_rst = status.frame_active && status.in_reset;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            lcfe_pkg::ST_COPY:
            begin
                cmd.copy_rd = 1'b1;
            end
            lcfe_pkg::ST_BIT:
            begin
                cmd.emit_bit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/lcfe_datapath.sv */
// Datapath of the LED chain frame encoder: pixel and frame stores, sweep counter,
// frame position counters and the result register. Depends on lcfe_pkg and lcfe_ram.

module lcfe_datapath #(
    parameter int MAX_LEDS    = 64,
    parameter int RESET_SLOTS = 80
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lcfe_pkg::cmd_t    cmd,
    output lcfe_pkg::status_t status,
    input  logic [7:0]        pixel_index,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    input  logic [7:0]        chain_len,
    input  logic [15:0]       one_duty,
    input  logic [15:0]       zero_duty,
    output logic              count_clamp,
    output logic              slot_valid,
    output logic [15:0]       slot_duty,
    output logic              frame_last
);

    localparam int AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW   = $clog2(MAX_LEDS + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int RW   = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;
    localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_LEDS - 1);
    localparam logic [CMPW-1:0] MAX_CMP   = CMPW'(MAX_LEDS);
    localparam logic [RW-1:0]   LAST_RST  = RW'(RESET_SLOTS - 1);
    localparam logic [4:0]      LAST_BIT  = 5'(lcfe_pkg::BITS_PER_LED - 1);

    logic                       frame_active_reg, frame_active_next;
    logic                       in_reset_reg, in_reset_next;
    logic [CW-1:0]              frame_leds_reg, frame_leds_next;
    logic [CW-1:0]              led_pos_reg, led_pos_next;
    logic [4:0]                 bit_pos_reg, bit_pos_next;
    logic [RW-1:0]              rst_pos_reg, rst_pos_next;
    logic [AW-1:0]              sweep_reg, sweep_next;
    logic [AW-1:0]              last_reg, last_next;
    logic                       fill_zero_reg, fill_zero_next;
    logic                       copy_pend_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [lcfe_pkg::PIX_W-1:0] color_reg, color_next;
    logic [AW-1:0]              copy_addr_reg, copy_addr_next;
    logic [15:0]                duty_reg, duty_next;
    logic                       last_flag_reg, last_flag_next;

    logic [lcfe_pkg::PIX_W-1:0] in_color;
    logic [lcfe_pkg::PIX_W-1:0] fill_data;
    logic [lcfe_pkg::PIX_W-1:0] pix_rd_data;
    logic [lcfe_pkg::PIX_W-1:0] frame_rd_data;
    logic [CMPW-1:0]            idx_ext;
    logic [CMPW-1:0]            cnt_ext;
    logic [CMPW-1:0]            eff_cnt;
    logic [CMPW-1:0]            frame_cnt;
    logic [CMPW-1:0]            frame_last_idx;
    logic [CMPW-1:0]            fill_cnt;
    logic [CMPW-1:0]            fill_last_idx;
    logic                       count_over;
    logic                       idx_ok;
    logic [CW-1:0]              led_pos_inc;
    logic [4:0]                 bit_sel;
    logic                       pix_wr_en;
    logic [AW-1:0]              pix_wr_addr;
    logic [lcfe_pkg::PIX_W-1:0] pix_wr_data;

    assign in_color  = {green, red, blue};
    assign fill_data = fill_zero_reg ? '0 : color_reg;

    // Frame length: a count of zero means the default, and MAX_LEDS caps it.
    assign cnt_ext        = CMPW'(chain_len);
    assign eff_cnt        = (chain_len == 8'd0) ? CMPW'(lcfe_pkg::DEFAULT_LEDS) : cnt_ext;
    assign count_over     = eff_cnt > MAX_CMP;
    assign frame_cnt      = count_over ? MAX_CMP : eff_cnt;
    assign frame_last_idx = frame_cnt - CMPW'(1);
    assign count_clamp    = cmd.copy_begin && count_over;

    // Set_all covers the entries below both the chain length and MAX_LEDS.
    assign fill_cnt      = (cnt_ext > MAX_CMP) ? MAX_CMP : cnt_ext;
    assign fill_last_idx = fill_cnt - CMPW'(1);

    assign idx_ext = CMPW'(pixel_index);
    assign idx_ok  = (idx_ext < cnt_ext) && (idx_ext < MAX_CMP);

    assign led_pos_inc = led_pos_reg + CW'(1);
    assign bit_sel     = LAST_BIT - bit_pos_reg;

    assign status.frame_active  = frame_active_reg;
    assign status.in_reset      = in_reset_reg;
    assign status.sweep_last    = (sweep_reg == last_reg);
    assign status.fill_nonempty = (chain_len != 8'd0);

    assign pix_wr_en   = cmd.fill_wr || (cmd.pixel_wr && idx_ok);
    assign pix_wr_addr = cmd.fill_wr ? sweep_reg : idx_ext[AW-1:0];
    assign pix_wr_data = cmd.fill_wr ? fill_data : in_color;

    lcfe_ram #(
        .WIDTH (lcfe_pkg::PIX_W),
        .DEPTH (MAX_LEDS)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (pix_wr_addr),
        .wr_data (pix_wr_data),
        .rd_en   (cmd.copy_rd),
        .rd_addr (sweep_reg),
        .rd_data (pix_rd_data)
    );

    lcfe_ram #(
        .WIDTH (lcfe_pkg::PIX_W),
        .DEPTH (MAX_LEDS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (copy_pend_reg),
        .wr_addr (copy_addr_reg),
        .wr_data (pix_rd_data),
        .rd_en   (cmd.tick_rd),
        .rd_addr (led_pos_reg[AW-1:0]),
        .rd_data (frame_rd_data)
    );

    always_comb
    begin
        frame_active_next = frame_active_reg;
        in_reset_next     = in_reset_reg;
        frame_leds_next   = frame_leds_reg;
        led_pos_next      = led_pos_reg;
        bit_pos_next      = bit_pos_reg;
        rst_pos_next      = rst_pos_reg;
        sweep_next        = sweep_reg;
        last_next         = last_reg;
        fill_zero_next    = fill_zero_reg;
        color_next        = color_reg;
        copy_addr_next    = copy_addr_reg;
        out_valid_next    = 1'b0;
        duty_next         = duty_reg;
        last_flag_next    = last_flag_reg;

        if (cmd.fill_begin)
        begin
            sweep_next     = '0;
            fill_zero_next = cmd.fill_clear;
            color_next     = in_color;
            last_next      = cmd.fill_clear ? LAST_ADDR : fill_last_idx[AW-1:0];
        end

        if (cmd.fill_wr)
        begin
            sweep_next = sweep_reg + AW'(1);
        end

        if (cmd.copy_begin)
        begin
            sweep_next        = '0;
            last_next         = frame_last_idx[AW-1:0];
            frame_leds_next   = frame_cnt[CW-1:0];
            frame_active_next = 1'b1;
            in_reset_next     = 1'b0;
            led_pos_next      = '0;
            bit_pos_next      = '0;
            rst_pos_next      = '0;
        end

        if (cmd.copy_rd)
        begin
            sweep_next     = sweep_reg + AW'(1);
            copy_addr_next = sweep_reg;
        end

        if (cmd.emit_bit)
        begin
            out_valid_next = 1'b1;
            duty_next      = frame_rd_data[bit_sel] ? one_duty : zero_duty;
            last_flag_next = 1'b0;
            if (bit_pos_reg == LAST_BIT)
            begin
                bit_pos_next = '0;
                led_pos_next = led_pos_inc;
                if (led_pos_inc == frame_leds_reg)
                begin
                    in_reset_next = 1'b1;
                    rst_pos_next  = '0;
                end
            end
            else
            begin
                bit_pos_next = bit_pos_reg + 5'd1;
            end
        end

        if (cmd.emit_rst)
        begin
            out_valid_next = 1'b1;
            duty_next      = 16'd0;
            last_flag_next = (rst_pos_reg == LAST_RST);
            if (rst_pos_reg == LAST_RST)
            begin
                frame_active_next = 1'b0;
                in_reset_next     = 1'b0;
                led_pos_next      = '0;
                bit_pos_next      = '0;
                rst_pos_next      = '0;
            end
            else
            begin
                rst_pos_next = rst_pos_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            in_reset_reg     <= 1'b0;
            frame_leds_reg   <= '0;
            led_pos_reg      <= '0;
            bit_pos_reg      <= '0;
            rst_pos_reg      <= '0;
            sweep_reg        <= '0;
            last_reg         <= LAST_ADDR;
            fill_zero_reg    <= 1'b1;
            copy_pend_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_active_reg <= frame_active_next;
            in_reset_reg     <= in_reset_next;
            frame_leds_reg   <= frame_leds_next;
            led_pos_reg      <= led_pos_next;
            bit_pos_reg      <= bit_pos_next;
            rst_pos_reg      <= rst_pos_next;
            sweep_reg        <= sweep_next;
            last_reg         <= last_next;
            fill_zero_reg    <= fill_zero_next;
            copy_pend_reg    <= cmd.copy_rd;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        copy_addr_reg <= copy_addr_next;
        duty_reg      <= duty_next;
        last_flag_reg <= last_flag_next;
    end

    assign slot_valid = out_valid_reg;
    assign slot_duty  = duty_reg;
    assign frame_last = last_flag_reg;

endmodule

/* hw/rtl/led_chain_frame_encoder.sv */
// Top level of the LED chain frame encoder: configuration registers on an APB-style
// port, plus the controller and datapath. Depends on lcfe_pkg, lcfe_ctrl, lcfe_datapath.
//
//  Channel    | Handshake                      | Payload
//  -----------+--------------------------------+------------------------------------------
//  request    | start high while busy low      | operation, pixel_index, red, green, blue
//  result     | slot_valid, one cycle, no stall| slot_duty, frame_last
//  config     | psel & penable & pwrite        | paddr, pwdata (prdata on reads)
//
// Set_pixel writes one entry. Clear sweeps all MAX_LEDS entries of the pixel RAM and
// set_all the first N (the chain length capped at MAX_LEDS), one entry a cycle. Show
// copies the frame through the pixel RAM read port, where a chain length of zero
// counts as 64 before the cap. A slot tick during the data bits reads the frame RAM,
// then selects the bit; a tick in the reset slots emits at once. Each result is
// registered and appears in the cycle after its last step. After reset, a clearing
// pass zeroes the pixel store while busy is high.
// The result side cannot stall, so results never hold up the block.

module led_chain_frame_encoder #(
    parameter int MAX_LEDS    = 64,
    parameter int RESET_SLOTS = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel.
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  operation,
    input  logic [7:0]  pixel_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    // Result channel.
    output logic        slot_valid,
    output logic [15:0] slot_duty,
    output logic        frame_last,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Show rewrites the chain length register to this when the requested count
    // exceeds MAX_LEDS.
    localparam logic [7:0] CHAIN_LEN_CLAMP = 8'(MAX_LEDS % 256);

    logic [7:0]        chain_len_reg, chain_len_next;
    logic [15:0]       one_duty_reg, one_duty_next;
    logic [15:0]       zero_duty_reg, zero_duty_next;
    logic              cfg_wr;
    logic [1:0]        reg_index;
    logic              count_clamp;
    lcfe_pkg::cmd_t    cmd;
    lcfe_pkg::status_t status;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    // Register writes. The user must change configuration only while the block is idle;
    // the block does not enforce it, and a bus write to the chain length in the cycle of a show's clamp wins.
    always_comb
    begin
        chain_len_next = chain_len_reg;
        one_duty_next  = one_duty_reg;
        zero_duty_next = zero_duty_reg;
        if (count_clamp)
        begin
            chain_len_next = CHAIN_LEN_CLAMP;
        end
        if (cfg_wr)
        begin
            case (reg_index)
                lcfe_pkg::REG_CHAIN_LEN: chain_len_next = pwdata[7:0];
                lcfe_pkg::REG_ONE_DUTY:  one_duty_next  = pwdata[15:0];
                lcfe_pkg::REG_ZERO_DUTY: zero_duty_next = pwdata[15:0];
                default:                 chain_len_next = chain_len_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_len_reg <= lcfe_pkg::CHAIN_LEN_RST;
            one_duty_reg  <= lcfe_pkg::ONE_DUTY_RST;
            zero_duty_reg <= lcfe_pkg::ZERO_DUTY_RST;
        end
        else
        begin
            chain_len_reg <= chain_len_next;
            one_duty_reg  <= one_duty_next;
            zero_duty_reg <= zero_duty_next;
        end
    end

    // Read data; addresses past the register list read as zero.
    always_comb
    begin
        case (reg_index)
            lcfe_pkg::REG_CHAIN_LEN: prdata = {24'd0, chain_len_reg};
            lcfe_pkg::REG_ONE_DUTY:  prdata = {16'd0, one_duty_reg};
            lcfe_pkg::REG_ZERO_DUTY: prdata = {16'd0, zero_duty_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    lcfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    lcfe_datapath #(
        .MAX_LEDS    (MAX_LEDS),
        .RESET_SLOTS (RESET_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .chain_len   (chain_len_reg),
        .one_duty    (one_duty_reg),
        .zero_duty   (zero_duty_reg),
        .count_clamp (count_clamp),
        .slot_valid  (slot_valid),
        .slot_duty   (slot_duty),
        .frame_last  (frame_last)
    );

endmodule
